@@ sv/flacfh_pkg.sv @@
// types, codes and lookup functions shared by the frame header parser
// no dependencies
package flacfh_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned BlkW   = 17;
  localparam int unsigned RateW  = 20;
  localparam int unsigned StatW  = 2;
  localparam int unsigned SkipW  = 3;
  localparam int unsigned CodeW  = 4;

  localparam logic [RateW-1:0] DefaultRate = RateW'(44100);

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_FN  = 2'd1;
  localparam logic [StatW-1:0] ST_CRC_BAD = 2'd2;

  localparam logic [CodeW-1:0] BS_BYTE8  = 4'd6;
  localparam logic [CodeW-1:0] BS_BYTE16 = 4'd7;
  localparam logic [CodeW-1:0] SR_RAW8   = 4'hC;
  localparam logic [CodeW-1:0] SR_HZ16   = 4'hD;
  localparam logic [CodeW-1:0] SR_TENS16 = 4'hE;
  localparam logic [CodeW-1:0] SR_DEFLT  = 4'h0;

  localparam logic [ByteW-1:0] CrcPoly = 8'h07;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC_LO,
    PH_CODES,
    PH_CHAN,
    PH_FN_LEAD,
    PH_FN_CONT,
    PH_BS,
    PH_SR,
    PH_CRC
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic             start_of_header;
  } in_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [BlkW-1:0]  blk_samples;
    logic [RateW-1:0] fs_hz;
  } out_t;

  // msb-first crc-8, one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      c = c[ByteW-1] ? ({c[ByteW-2:0], 1'b0} ^ CrcPoly) : {c[ByteW-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [BlkW-1:0] blk_lookup(input logic [CodeW-1:0] code);
    logic [BlkW-1:0] v;
    case (code)
      4'd1:    v = BlkW'(192);
      4'd2:    v = BlkW'(576);
      4'd3:    v = BlkW'(1152);
      4'd4:    v = BlkW'(2304);
      4'd5:    v = BlkW'(4608);
      4'd8:    v = BlkW'(256);
      4'd9:    v = BlkW'(512);
      4'd10:   v = BlkW'(1024);
      4'd11:   v = BlkW'(2048);
      4'd12:   v = BlkW'(4096);
      4'd13:   v = BlkW'(8192);
      4'd14:   v = BlkW'(16384);
      4'd15:   v = BlkW'(32768);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [RateW-1:0] rate_lookup(input logic [CodeW-1:0] code);
    logic [RateW-1:0] v;
    case (code)
      4'd1:    v = RateW'(88200);
      4'd2:    v = RateW'(176400);
      4'd3:    v = RateW'(192000);
      4'd4:    v = RateW'(8000);
      4'd5:    v = RateW'(16000);
      4'd6:    v = RateW'(22050);
      4'd7:    v = RateW'(24000);
      4'd8:    v = RateW'(32000);
      4'd9:    v = RateW'(44100);
      4'd10:   v = RateW'(48000);
      4'd11:   v = RateW'(96000);
      4'd15:   v = RateW'(15);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/flacfh_parser.sv @@
// per-byte header parse state and the result of one byte
// depends on flacfh_pkg
module flacfh_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  flacfh_pkg::in_t               in_i,
  input  logic [flacfh_pkg::RateW-1:0]  dflt_rate_i,
  output logic                          res_valid_o,
  output flacfh_pkg::out_t              res_o
);
  import flacfh_pkg::*;

  phase_e           phase_q, phase_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [CodeW-1:0] blk_code_q, blk_code_d;
  logic [CodeW-1:0] rate_code_q, rate_code_d;
  logic [BlkW-1:0]  blk_acc_q, blk_acc_d;
  logic [RateW-1:0] rate_acc_q, rate_acc_d;
  logic [ByteW-1:0] crc_q, crc_d;

  logic [ByteW-1:0] b;
  logic [3:0]       ones;
  logic             run;
  logic [SkipW-1:0] skip_dec;
  phase_e           after_fn_ph, after_bs_ph;
  logic [SkipW-1:0] after_fn_skip, after_bs_skip;
  logic [BlkW-1:0]  blk_final;
  logic [RateW-1:0] rate_final;
  logic [RateW-1:0] rate_x10;

  assign b        = in_i.header_byte;
  assign skip_dec = skip_q - SkipW'(1);

  // leading ones of the lead byte
  always_comb begin
    ones = '0;
    run  = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      ones = ones + {3'b000, run};
    end
  end

  // phase entered once the optional block-size or rate bytes are due
  always_comb begin
    if (rate_code_q == SR_RAW8) begin
      after_bs_ph   = PH_SR;
      after_bs_skip = SkipW'(1);
    end else if (rate_code_q == SR_HZ16 || rate_code_q == SR_TENS16) begin
      after_bs_ph   = PH_SR;
      after_bs_skip = SkipW'(2);
    end else begin
      after_bs_ph   = PH_CRC;
      after_bs_skip = '0;
    end
    if (blk_code_q == BS_BYTE8) begin
      after_fn_ph   = PH_BS;
      after_fn_skip = SkipW'(1);
    end else if (blk_code_q == BS_BYTE16) begin
      after_fn_ph   = PH_BS;
      after_fn_skip = SkipW'(2);
    end else begin
      after_fn_ph   = after_bs_ph;
      after_fn_skip = after_bs_skip;
    end
  end

  assign rate_x10 = {rate_acc_q[RateW-4:0], 3'b000} + {rate_acc_q[RateW-2:0], 1'b0};

  always_comb begin
    if (blk_code_q == BS_BYTE8 || blk_code_q == BS_BYTE16) begin
      blk_final = blk_acc_q + BlkW'(1);
    end else begin
      blk_final = blk_lookup(blk_code_q);
    end
    if (rate_code_q == SR_DEFLT) begin
      rate_final = dflt_rate_i;
    end else if (rate_code_q == SR_RAW8 || rate_code_q == SR_HZ16) begin
      rate_final = rate_acc_q;
    end else if (rate_code_q == SR_TENS16) begin
      rate_final = rate_x10;
    end else begin
      rate_final = rate_lookup(rate_code_q);
    end
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    blk_code_d  = blk_code_q;
    rate_code_d = rate_code_q;
    blk_acc_d   = blk_acc_q;
    rate_acc_d  = rate_acc_q;
    crc_d       = crc8_byte(crc_q, b);
    if (in_i.start_of_header) begin
      phase_d     = PH_SYNC_LO;
      skip_d      = '0;
      blk_code_d  = '0;
      rate_code_d = '0;
      blk_acc_d   = '0;
      rate_acc_d  = '0;
      crc_d       = crc8_byte('0, b);
    end else begin
      case (phase_q)
        PH_SYNC_LO: begin
          phase_d = PH_CODES;
        end
        PH_CODES: begin
          blk_code_d  = b[7:4];
          rate_code_d = b[3:0];
          phase_d     = PH_CHAN;
        end
        PH_CHAN: begin
          phase_d = PH_FN_LEAD;
        end
        PH_FN_LEAD: begin
          if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
            phase_d = PH_IDLE;
          end else if (ones >= 4'd2) begin
            skip_d  = SkipW'(ones - 4'd1);
            phase_d = PH_FN_CONT;
          end else begin
            skip_d  = after_fn_skip;
            phase_d = after_fn_ph;
          end
        end
        PH_FN_CONT: begin
          if (b[7:6] != 2'b10) begin
            phase_d = PH_IDLE;
          end else if (skip_dec == '0) begin
            skip_d  = after_fn_skip;
            phase_d = after_fn_ph;
          end else begin
            skip_d = skip_dec;
          end
        end
        PH_BS: begin
          blk_acc_d = {blk_acc_q[BlkW-9:0], b};
          if (skip_dec == '0) begin
            skip_d  = after_bs_skip;
            phase_d = after_bs_ph;
          end else begin
            skip_d = skip_dec;
          end
        end
        PH_SR: begin
          rate_acc_d = {rate_acc_q[RateW-9:0], b};
          skip_d     = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_CRC;
          end
        end
        default: begin
          // idle and the crc byte leave the running crc alone
          crc_d   = crc_q;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // result of this byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!in_i.start_of_header) begin
      case (phase_q)
        PH_CRC: begin
          res_valid_o = 1'b1;
          if (b == crc_q) begin
            res_o.status      = ST_OK;
            res_o.blk_samples = blk_final;
            res_o.fs_hz       = rate_final;
          end else begin
            res_o.status = ST_CRC_BAD;
          end
        end
        PH_FN_LEAD: begin
          if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_BAD_FN;
          end
        end
        PH_FN_CONT: begin
          if (b[7:6] != 2'b10) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_BAD_FN;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      skip_q      <= '0;
      blk_code_q  <= '0;
      rate_code_q <= '0;
      blk_acc_q   <= '0;
      rate_acc_q  <= '0;
      crc_q       <= '0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      blk_code_q  <= blk_code_d;
      rate_code_q <= rate_code_d;
      blk_acc_q   <= blk_acc_d;
      rate_acc_q  <= rate_acc_d;
      crc_q       <= crc_d;
    end
  end

endmodule

@@ sv/flac_frame_header_parser_unit.sv @@
// top level of the frame header parser: input register, result register, config
// depends on flacfh_pkg and flacfh_parser
//
// Takes a frame header one byte per word, the first sync byte flagged by
// start_of_header, and gives one result word on the CRC byte or at once on a
// bad coded frame number; other bytes give no result. A byte is accepted every
// cycle unless a stalled output holds it back: it is held in the input register
// while the parse logic updates the header state in a single pass, and its
// result lands in the output register, which drives out_o and out_valid_o. A
// stalled output only holds back a byte that would give a result. The default
// sample rate register may be written at any time the parser is idle; writes
// are always accepted.
module flac_frame_header_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  flacfh_pkg::in_t               in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output flacfh_pkg::out_t              out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [flacfh_pkg::RateW-1:0]  cfg_data_i
);
  import flacfh_pkg::*;

  logic             in_valid_q;
  in_t              in_q;
  logic             out_valid_q;
  out_t             out_q;
  logic [RateW-1:0] dflt_rate_q;
  logic             res_valid;
  out_t             res;
  logic             advance;

  // a byte with no result never waits on the output
  assign advance     = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  flacfh_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .in_i        (in_q),
    .dflt_rate_i (dflt_rate_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dflt_rate_q <= DefaultRate;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        dflt_rate_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  a_err_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.blk_samples == '0 && out_q.fs_hz == '0)
    else $error("error result carries non-zero payload");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.status == ST_OK || out_q.status == ST_BAD_FN ||
                    out_q.status == ST_CRC_BAD)
    else $error("result status out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && in_valid_q && res_valid |-> !advance)
    else $error("pending result overwritten");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> out_valid_q)
    else $error("result lost on its way to the output register");

endmodule

@@ test/flac_frame_header_parser_unit_test.sv @@
// self-checking bench for the frame header parser: headers with random content fed
// through valid/ready with random stalls, results checked against a local parser model
// depends on flacfh_pkg and flac_frame_header_parser_unit
module flac_frame_header_parser_unit_test;
  import flacfh_pkg::*;

  localparam int SettleCycles = 4;
  localparam int CycleLimit   = 200000;

  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} feed_kind_e;
  typedef enum logic [2:0] {FLAW_NONE, FLAW_CRC, FLAW_LEAD, FLAW_CONT, FLAW_CUT} flaw_e;

  typedef struct packed {
    feed_kind_e       kind;
    in_t              word;
    logic [RateW-1:0] rate;
  } feed_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_v = 1'b0;
  in_t              in_w = '0;
  logic             in_ready;
  logic             out_valid;
  logic             out_rdy = 1'b0;
  out_t             out_w;
  logic             cfg_v = 1'b0;
  logic [RateW-1:0] cfg_w = '0;
  logic             cfg_ready;

  flac_frame_header_parser_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_v),
    .in_ready_o  (in_ready),
    .in_i        (in_w),
    .out_valid_o (out_valid),
    .out_ready_i (out_rdy),
    .out_o       (out_w),
    .cfg_valid_i (cfg_v),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_w)
  );

  always #2 clk = ~clk;

  feed_op_t pending_ops [$];
  out_t     headers_due [$];
  int       queued = 0;
  int       taken_count = 0;
  int       faults = 0;
  int       cycles = 0;
  int       quiet = 0;
  logic     in_took = 1'b0;
  logic     cfg_took = 1'b0;
  logic     feed_done = 1'b0;
  logic     calm;

  // model of the header parser
  phase_e           ph = PH_IDLE;
  logic [SkipW-1:0] skip = '0;
  logic [CodeW-1:0] bcode = '0;
  logic [CodeW-1:0] rcode = '0;
  logic [BlkW-1:0]  bacc = '0;
  logic [RateW-1:0] racc = '0;
  logic [ByteW-1:0] crc = '0;
  logic [RateW-1:0] deflt_hz = DefaultRate;
  logic [BlkW-1:0]  blk_by_code [16];
  logic [RateW-1:0] hz_by_code [16];

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  task automatic track_header_byte(input in_t w);
    logic [7:0] b;
    out_t r;
    logic give;
    logic after_fn;
    logic to_rate;
    int ones;
    b = w.header_byte;
    r = '0;
    give = 1'b0;
    after_fn = 1'b0;
    to_rate = 1'b0;
    if (w.start_of_header) begin
      ph = PH_SYNC_LO;
      skip = '0;
      bcode = '0;
      rcode = '0;
      bacc = '0;
      racc = '0;
      crc = crc8_step(8'h00, b);
    end else if (ph == PH_CRC) begin
      ph = PH_IDLE;
      give = 1'b1;
      if (b == crc) begin
        r.status = ST_OK;
        if (bcode == BS_BYTE8 || bcode == BS_BYTE16) r.blk_samples = bacc + 17'd1;
        else r.blk_samples = blk_by_code[bcode];
        case (rcode)
          SR_DEFLT:          r.fs_hz = deflt_hz;
          SR_RAW8, SR_HZ16:  r.fs_hz = racc;
          SR_TENS16:         r.fs_hz = racc * 20'd10;
          default:           r.fs_hz = hz_by_code[rcode];
        endcase
      end else begin
        r.status = ST_CRC_BAD;
      end
    end else if (ph != PH_IDLE) begin
      crc = crc8_step(crc, b);
      case (ph)
        PH_SYNC_LO: ph = PH_CODES;
        PH_CODES: begin
          bcode = b[7:4];
          rcode = b[3:0];
          ph = PH_CHAN;
        end
        PH_CHAN: ph = PH_FN_LEAD;
        PH_FN_LEAD: begin
          if (b[7:6] == 2'b10 || b >= 8'hFE) begin
            ph = PH_IDLE;
            give = 1'b1;
            r.status = ST_BAD_FN;
          end else begin
            ones = 0;
            while (ones < 8 && b[7 - ones]) ones++;
            if (ones >= 2) begin
              skip = SkipW'(ones - 1);
              ph = PH_FN_CONT;
            end else begin
              after_fn = 1'b1;
            end
          end
        end
        PH_FN_CONT: begin
          if (b[7:6] != 2'b10) begin
            ph = PH_IDLE;
            give = 1'b1;
            r.status = ST_BAD_FN;
          end else begin
            skip = skip - 1'b1;
            if (skip == '0) after_fn = 1'b1;
          end
        end
        PH_BS: begin
          bacc = {bacc[8:0], b};
          skip = skip - 1'b1;
          if (skip == '0) to_rate = 1'b1;
        end
        PH_SR: begin
          racc = {racc[11:0], b};
          skip = skip - 1'b1;
          if (skip == '0) ph = PH_CRC;
        end
        default: ph = PH_IDLE;
      endcase
      if (after_fn) begin
        if (bcode == BS_BYTE8) begin
          skip = 3'd1;
          ph = PH_BS;
        end else if (bcode == BS_BYTE16) begin
          skip = 3'd2;
          ph = PH_BS;
        end else begin
          to_rate = 1'b1;
        end
      end
      if (to_rate) begin
        if (rcode == SR_RAW8) begin
          skip = 3'd1;
          ph = PH_SR;
        end else if (rcode == SR_HZ16 || rcode == SR_TENS16) begin
          skip = 3'd2;
          ph = PH_SR;
        end else begin
          ph = PH_CRC;
        end
      end
    end
    if (give) headers_due.push_back(r);
  endtask

  function automatic logic [7:0] edgy_byte();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s);
    feed_op_t op;
    op = '0;
    op.kind = OP_BYTE;
    op.word.header_byte = b;
    op.word.start_of_header = s;
    pending_ops.push_back(op);
    queued++;
  endtask

  task automatic push_ctrl(input feed_kind_e kind, input logic [RateW-1:0] rate);
    feed_op_t op;
    op = '0;
    op.kind = kind;
    op.rate = rate;
    pending_ops.push_back(op);
  endtask

  // builds one header with a correct crc, then spoils it as asked
  task automatic queue_header(input logic [3:0] bc, input logic [3:0] rc, input int fn_len,
                              input flaw_e flaw, input int pad);
    logic [7:0] hb [$];
    logic [7:0] c;
    logic [7:0] lead;
    logic [1:0] top;
    int nb;
    int stop;
    int at;
    hb.push_back(($urandom_range(3) != 0) ? 8'hFF : 8'($urandom));
    hb.push_back(($urandom_range(1) != 0) ? 8'hF8 : 8'($urandom));
    hb.push_back({bc, rc});
    hb.push_back(8'($urandom));
    if (fn_len < 2) begin
      hb.push_back({1'b0, 7'($urandom)});
    end else begin
      lead = 8'hFF << (8 - fn_len);
      lead = lead | (8'($urandom) & (8'hFF >> (fn_len + 1)));
      hb.push_back(lead);
      for (int k = 1; k < fn_len; k++) hb.push_back({2'b10, 6'($urandom)});
    end
    nb = (bc == BS_BYTE16) ? 2 : (bc == BS_BYTE8) ? 1 : 0;
    nb += (rc == SR_RAW8) ? 1 : (rc == SR_HZ16 || rc == SR_TENS16) ? 2 : 0;
    for (int k = 0; k < nb; k++) hb.push_back((pad < 0) ? edgy_byte() : 8'(pad));
    c = 8'h00;
    foreach (hb[i]) c = crc8_step(c, hb[i]);
    hb.push_back((flaw == FLAW_CRC) ? (c ^ 8'($urandom_range(255, 1))) : c);
    stop = hb.size();
    case (flaw)
      FLAW_LEAD: begin
        case ($urandom_range(2))
          0:       hb[4] = {2'b10, 6'($urandom)};
          1:       hb[4] = 8'hFE;
          default: hb[4] = 8'hFF;
        endcase
        stop = 5;
      end
      FLAW_CONT: begin
        at = 5 + $urandom_range(fn_len - 2);
        top = 2'($urandom_range(2));
        if (top == 2'b10) top = 2'b11;
        hb[at] = {top, 6'($urandom)};
        stop = at + 1;
      end
      FLAW_CUT: stop = 1 + $urandom_range(hb.size() - 2);
      default: ;
    endcase
    for (int i = 0; i < stop; i++) push_byte(hb[i], i == 0);
  endtask

  // mostly well-formed headers, the rest broken ones and loose bytes
  task automatic queue_random(input int n);
    int goal;
    int r;
    int fl;
    logic [3:0] rc;
    goal = queued + n;
    while (queued < goal) begin
      r = $urandom_range(99);
      fl = $urandom_range(1, 6);
      rc = ($urandom_range(4) == 0) ? SR_DEFLT : 4'($urandom);
      if (r < 62) queue_header(4'($urandom), rc, fl, FLAW_NONE, -1);
      else if (r < 72) queue_header(4'($urandom), rc, fl, FLAW_CRC, -1);
      else if (r < 78) queue_header(4'($urandom), rc, fl, FLAW_LEAD, -1);
      else if (r < 86) queue_header(4'($urandom), rc, (fl < 2) ? 2 : fl, FLAW_CONT, -1);
      else if (r < 93) queue_header(4'($urandom), rc, fl, FLAW_CUT, -1);
      else repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end
    // leave the parser idle at the end of the phase
    queue_header(4'($urandom), SR_DEFLT, 1, FLAW_NONE, -1);
  endtask

  assign calm = (taken_count >= 150) && (taken_count < 260);

  always @(negedge clk) begin : drive_words
    logic nv;
    logic ncv;
    in_t nw;
    logic [RateW-1:0] nd;
    nv = in_v && !in_took;
    ncv = cfg_v && !cfg_took;
    nw = in_w;
    nd = cfg_w;
    if (rst_n) begin
      if (!nv && !ncv && pending_ops.size() != 0) begin
        case (pending_ops[0].kind)
          OP_BYTE: begin
            if (calm || $urandom_range(99) >= 26) begin
              nv = 1'b1;
              nw = pending_ops[0].word;
              void'(pending_ops.pop_front());
            end
          end
          OP_CFG: begin
            if (quiet >= SettleCycles) begin
              ncv = 1'b1;
              nd = pending_ops[0].rate;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (quiet >= SettleCycles) void'(pending_ops.pop_front());
          end
        endcase
      end
      if (nv || ncv || in_v || headers_due.size() != 0) quiet <= 0;
      else quiet <= quiet + 1;
      out_rdy <= calm || ($urandom_range(99) >= 26);
      feed_done <= (pending_ops.size() == 0) && !nv && !ncv;
    end
    in_v <= nv;
    in_w <= nw;
    cfg_v <= ncv;
    cfg_w <= nd;
  end

  always @(posedge clk) begin : watch_results
    out_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      in_took <= in_v && in_ready;
      cfg_took <= cfg_v && cfg_ready;
      if (out_valid && out_rdy) begin
        if (headers_due.size() == 0) begin
          $display("%0t: unexpected result status %0d block %0d rate %0d", $time,
                   out_w.status, out_w.blk_samples, out_w.fs_hz);
          faults++;
        end else begin
          want = headers_due.pop_front();
          if (out_w.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_w.status);
            faults++;
          end
          if (out_w.blk_samples != want.blk_samples) begin
            $display("%0t: blk_samples expected %0d actual %0d", $time, want.blk_samples,
                     out_w.blk_samples);
            faults++;
          end
          if (out_w.fs_hz != want.fs_hz) begin
            $display("%0t: fs_hz expected %0d actual %0d", $time, want.fs_hz,
                     out_w.fs_hz);
            faults++;
          end
        end
      end
      if (cfg_v && cfg_ready) deflt_hz = cfg_w;
      if (in_v && in_ready) begin
        track_header_byte(in_w);
        taken_count++;
      end
    end
  end

  initial begin
    blk_by_code = '{17'd0, 17'd192, 17'd576, 17'd1152, 17'd2304, 17'd4608, 17'd0, 17'd0,
                    17'd256, 17'd512, 17'd1024, 17'd2048, 17'd4096, 17'd8192, 17'd16384,
                    17'd32768};
    hz_by_code = '{20'd0, 20'd88200, 20'd176400, 20'd192000, 20'd8000, 20'd16000,
                   20'd22050, 20'd24000, 20'd32000, 20'd44100, 20'd48000, 20'd96000,
                   20'd0, 20'd0, 20'd0, 20'd15};

    // directed: a loose byte while idle, smallest and largest headers, a bad lead byte
    push_byte(8'h00, 1'b0);
    queue_header(4'd0, SR_DEFLT, 1, FLAW_NONE, 0);
    queue_header(BS_BYTE16, SR_TENS16, 6, FLAW_NONE, 255);
    queue_header(BS_BYTE8, SR_RAW8, 1, FLAW_LEAD, 255);

    push_ctrl(OP_CFG, '0);
    queue_random(130);
    push_ctrl(OP_CFG, '1);
    queue_random(70);
    // sender holds off until every result is in
    push_ctrl(OP_DRAIN, '0);
    queue_random(60);
    push_ctrl(OP_CFG, RateW'($urandom));
    queue_random(130);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(feed_done && headers_due.size() == 0)) @(negedge clk);
    repeat (8) @(negedge clk);
    if (headers_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, headers_due.size());
      faults++;
    end
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
